[rtl/spr_pkg.sv]
// ============================================================================
// Stream pause/resume tracker package
// Shared constants, codes and types for the stream pause/resume tracker.
// ============================================================================
`default_nettype none

package spr_pkg;

  localparam int MAX_STREAMS_DEF = 16;

  // Event opcodes carried in an input word.
  localparam logic [2:0] OP_RTP        = 3'd0;
  localparam logic [2:0] OP_PAUSED     = 3'd1;
  localparam logic [2:0] OP_REFUSED    = 3'd2;
  localparam logic [2:0] OP_REQ_PAUSE  = 3'd3;
  localparam logic [2:0] OP_REQ_RESUME = 3'd4;
  localparam logic [2:0] OP_QUERY      = 3'd5;

  // Result codes carried in an output word.
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_PAUSED      = 3'd1;
  localparam logic [2:0] EV_REFUSED     = 3'd2;
  localparam logic [2:0] EV_RESUMED     = 3'd3;
  localparam logic [2:0] EV_SEND_PAUSE  = 3'd4;
  localparam logic [2:0] EV_SEND_RESUME = 3'd5;
  localparam logic [2:0] EV_QUERY       = 3'd6;

  // Per-stream states.
  localparam logic [1:0] ST_PLAYING    = 2'd0;
  localparam logic [1:0] ST_PAUSE_REQ  = 2'd1;
  localparam logic [1:0] ST_PAUSED     = 2'd2;
  localparam logic [1:0] ST_RESUME_REQ = 2'd3;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_DECIDE
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } spr_cmd_t;

  typedef struct packed {
    logic last_cmp;
    logic out_free;
  } spr_status_t;

  typedef struct packed {
    logic [31:0] ssrc;
    logic [1:0]  st;
    logic [15:0] pause_id;
  } entry_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] target_ssrc;
    logic [15:0] report_pause_id;
    logic        has_ext_seq;
    logic [31:0] ext_seq_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] event_ssrc;
    logic [31:0] sender_ssrc;
    logic [15:0] cur_pause_id;
    logic [31:0] ext_seq_out;
    logic [1:0]  cur_state;
    logic        table_full;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/spr_if.sv]
// ============================================================================
// Stream pause/resume tracker channels
// Valid/ready channels for event words in and result words out.
// ============================================================================
`default_nettype none

interface spr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] target_ssrc;
  logic [15:0] report_pause_id;
  logic        has_ext_seq;
  logic [31:0] ext_seq_in;

  modport source (
    output valid, opcode, target_ssrc, report_pause_id, has_ext_seq, ext_seq_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, target_ssrc, report_pause_id, has_ext_seq, ext_seq_in,
    output ready
  );
endinterface

interface spr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] event_ssrc;
  logic [31:0] sender_ssrc;
  logic [15:0] cur_pause_id;
  logic [31:0] ext_seq_out;
  logic [1:0]  cur_state;
  logic        table_full;

  modport source (
    output valid, event_res, event_ssrc, sender_ssrc, cur_pause_id, ext_seq_out,
           cur_state, table_full,
    input  ready
  );
  modport sink (
    input  valid, event_res, event_ssrc, sender_ssrc, cur_pause_id, ext_seq_out,
           cur_state, table_full,
    output ready
  );
endinterface

`default_nettype wire

[rtl/stream_pause_resume_tracker.sv]
// An event word is accepted only while the controller is idle. The table scan then
// reads one entry per cycle from the table memory, the last compare follows, and
// the commit writes the table and loads the output register once the output is
// free; the next event word is accepted after the commit.
// A result word waits in the output register while the next event is scanned.
// Synchronous reset empties the table at once (valid bits) and clears local_ssrc.
// ============================================================================
// Stream pause/resume tracker
// Tracks pause/resume state and pause ids of media streams keyed by source id.
// ============================================================================
`default_nettype none

module stream_pause_resume_tracker import spr_pkg::*; #(
  parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  spr_in_if.sink      in_stream,
  spr_out_if.source   out_stream
);

  spr_cmd_t    cmd;
  spr_status_t status;
  in_item_t    in_item;
  out_item_t   out_item;
  logic        in_ready;
  logic        out_valid;

  assign in_item.opcode          = in_stream.opcode;
  assign in_item.target_ssrc     = in_stream.target_ssrc;
  assign in_item.report_pause_id = in_stream.report_pause_id;
  assign in_item.has_ext_seq     = in_stream.has_ext_seq;
  assign in_item.ext_seq_in      = in_stream.ext_seq_in;
  assign in_stream.ready         = in_ready;

  assign out_stream.valid        = out_valid;
  assign out_stream.event_res    = out_item.event_res;
  assign out_stream.event_ssrc   = out_item.event_ssrc;
  assign out_stream.sender_ssrc  = out_item.sender_ssrc;
  assign out_stream.cur_pause_id = out_item.cur_pause_id;
  assign out_stream.ext_seq_out  = out_item.ext_seq_out;
  assign out_stream.cur_state    = out_item.cur_state;
  assign out_stream.table_full   = out_item.table_full;

  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  spr_datapath #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_item    (out_item),
    .out_valid   (out_valid),
    .out_ready   (out_stream.ready)
  );

endmodule

`default_nettype wire

[rtl/spr_ctrl.sv]
// ============================================================================
// Stream pause/resume tracker controller
// Sequences capture, table scan and commit of one event word at a time.
// ============================================================================
`default_nettype none

module spr_ctrl import spr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  spr_status_t status,
  output spr_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (in_valid) state_next = CS_SCAN;
      end
      CS_SCAN: begin
        if (status.last_cmp) state_next = CS_DECIDE;
      end
      CS_DECIDE: begin
        if (status.out_free) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      CS_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      CS_SCAN: begin
        cmd.scan = 1'b1;
      end
      CS_DECIDE: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/spr_datapath.sv]
// ============================================================================
// Stream pause/resume tracker datapath
// Stream table memory, scan pipeline, update logic and result register.
// ============================================================================
`default_nettype none

module spr_datapath import spr_pkg::*; #(
  parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  spr_cmd_t    cmd,
  output spr_status_t status,
  input  in_item_t    in_item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output out_item_t   out_item,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CNT_W = $clog2(MAX_STREAMS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_STREAMS - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_STREAMS);

  logic [31:0]            local_ssrc;
  in_item_t               item;
  logic [MAX_STREAMS-1:0] valid;
  entry_t                 mem [MAX_STREAMS];
  entry_t                 rd_q;
  logic [CNT_W-1:0]       cnt;
  logic                   rd_en;
  logic                   cmp_pend;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   hit_found;
  logic [IDX_W-1:0]       hit_idx;
  logic [1:0]             hit_st;
  logic [15:0]            hit_pid;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;

  logic                   is_mod;
  logic                   tracked;
  logic                   full;
  logic                   wr_need;
  logic [IDX_W-1:0]       slot;
  logic [1:0]             new_st;
  logic [15:0]            new_pid;
  out_item_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ssrc <= '0;
    end else if (cfg_wr_en) begin
      local_ssrc <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item <= in_item;
    end
  end

  // The scan reads one table entry per cycle; its compare follows in the next cycle.
  assign rd_en = cmd.scan && (cnt < CNT_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      cmp_pend <= 1'b0;
    end else begin
      cmp_pend <= rd_en;
      if (cmd.start) begin
        cnt <= '0;
      end else if (rd_en) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[cnt[IDX_W-1:0]];
      cmp_idx <= cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_pend) begin
      if (valid[cmp_idx] && (rd_q.ssrc == item.target_ssrc)) begin
        hit_found <= 1'b1;
      end
      // The lowest free slot is the first invalid one met by the scan.
      if (!valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_pend) begin
      if (valid[cmp_idx] && (rd_q.ssrc == item.target_ssrc)) begin
        hit_idx <= cmp_idx;
        hit_st  <= rd_q.st;
        hit_pid <= rd_q.pause_id;
      end
      if (!valid[cmp_idx] && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
  end

  assign status.last_cmp = cmp_pend && (cmp_idx == LAST_IDX);
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    is_mod  = (item.opcode == OP_PAUSED) || (item.opcode == OP_REFUSED) ||
              (item.opcode == OP_REQ_PAUSE) || (item.opcode == OP_REQ_RESUME);
    tracked = hit_found;
    full    = 1'b0;
    wr_need = 1'b0;
    slot    = hit_idx;
    new_st  = hit_st;
    new_pid = hit_pid;
    res     = '0;
    res.event_ssrc = item.target_ssrc;

    if (is_mod && !hit_found) begin
      if (free_found) begin
        tracked = 1'b1;
        slot    = free_idx;
        new_st  = ST_PLAYING;
        new_pid = '0;
      end else begin
        tracked = 1'b0;
        full    = 1'b1;
      end
    end

    if (is_mod && !full) begin
      wr_need = 1'b1;
      unique case (item.opcode)
        OP_PAUSED: begin
          new_st  = ST_PAUSED;
          new_pid = item.report_pause_id;
          res.event_res   = EV_PAUSED;
          res.ext_seq_out = item.has_ext_seq ? item.ext_seq_in : 32'd0;
        end
        OP_REFUSED: begin
          new_st  = ST_PLAYING;
          new_pid = item.report_pause_id;
          res.event_res = EV_REFUSED;
        end
        OP_REQ_PAUSE: begin
          new_st = ST_PAUSE_REQ;
          res.event_res   = EV_SEND_PAUSE;
          res.sender_ssrc = local_ssrc;
        end
        default: begin
          new_st = ST_RESUME_REQ;
          res.event_res   = EV_SEND_RESUME;
          res.sender_ssrc = local_ssrc;
        end
      endcase
    end else if ((item.opcode == OP_RTP) && hit_found &&
                 ((hit_st == ST_PAUSED) || (hit_st == ST_RESUME_REQ))) begin
      // Media seen again on a paused or resume-requested stream: back to playing, next pause id.
      wr_need = 1'b1;
      new_st  = ST_PLAYING;
      new_pid = hit_pid + 16'd1;
      res.event_res = EV_RESUMED;
    end else if (item.opcode == OP_QUERY) begin
      res.event_res = EV_QUERY;
    end

    res.cur_state    = tracked ? new_st : ST_PLAYING;
    res.cur_pause_id = tracked ? new_pid : 16'd0;
    res.table_full   = full;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_need) begin
      mem[slot] <= '{ssrc: item.target_ssrc, st: new_st, pause_id: new_pid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit && wr_need) begin
      valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/spr_checker.sv]
// ============================================================================
// Stream pause/resume tracker checker
// Port-level assertions on the tracker, attached to the top level by bind.
// ============================================================================
`default_nettype none

module spr_checker import spr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  event_res,
  input wire logic [15:0] cur_pause_id,
  input wire logic [31:0] ext_seq_out,
  input wire logic [1:0]  cur_state,
  input wire logic        table_full
);

  // One word at a time: the block is busy in the cycle after taking a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again in the cycle after an accept");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle and empty after reset");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |->
      ((event_res == EV_NONE) && (cur_state == ST_PLAYING) && (cur_pause_id == 16'd0)))
    else $error("table full result carries stream state");

  a_ext_only_paused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (ext_seq_out != 32'd0)) |-> (event_res == EV_PAUSED))
    else $error("extended sequence on a result other than paused");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(event_res) && $stable(cur_state)))
    else $error("stalled result word changed or vanished");

endmodule

bind stream_pause_resume_tracker spr_checker u_spr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_stream.valid),
  .in_ready     (in_stream.ready),
  .out_valid    (out_stream.valid),
  .out_ready    (out_stream.ready),
  .event_res    (out_stream.event_res),
  .cur_pause_id (out_stream.cur_pause_id),
  .ext_seq_out  (out_stream.ext_seq_out),
  .cur_state    (out_stream.cur_state),
  .table_full   (out_stream.table_full)
);

`default_nettype wire

[tb/stream_pause_resume_tracker_test.sv]
// ----------------------------------------------------------------------------
// Stream pause/resume tracker testbench
// Drives decoded stream events into the tracker and checks every result word
// against a directed row's word or a cycle-free predictor of the stream table.
// Directed rows cover the corner cases; random mostly well-formed pause/resume
// traffic then runs under several idling and back-pressure settings of both channels.
// ----------------------------------------------------------------------------
module stream_pause_resume_tracker_test import spr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_SIZE       = MAX_STREAMS_DEF;
  localparam int          RANDOM_PER_PHASE = 275;
  localparam int          HOLD_CYCLES      = 400;
  localparam int          CYCLE_LIMIT      = 300000;
  localparam int          PRINT_CAP        = 100;
  localparam logic [2:0]  OP_SPARE_6       = 3'd6;
  localparam logic [2:0]  OP_SPARE_7       = 3'd7;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  spr_in_if  in_s ();
  spr_out_if out_s ();

  stream_pause_resume_tracker dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_stream   (in_s),
    .out_stream  (out_s)
  );

  always #6 clk = ~clk;

  // Predictor copy of the stream table and the own source id.
  bit          trk_valid [TABLE_SIZE];
  logic [31:0] trk_ssrc  [TABLE_SIZE];
  logic [1:0]  trk_state [TABLE_SIZE];
  logic [15:0] trk_pid   [TABLE_SIZE];
  logic [31:0] own_ssrc;

  out_item_t   pending_results [$];
  dir_row_t    dir_rows [$];
  logic [31:0] stream_pool [16];
  logic [31:0] phase_ssrc [4];
  int          phase_tx [4] = '{0, 54, 0, 36};
  int          phase_rx [4] = '{0, 0, 54, 36};

  bit          row_typed;
  out_item_t   row_want;
  int          error_count;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_left;
  int          cycle_count;

  function automatic int find_stream(logic [31:0] id);
    for (int i = 0; i < TABLE_SIZE; i++)
      if (trk_valid[i] && trk_ssrc[i] == id) return i;
    return -1;
  endfunction

  function automatic out_item_t step_tracker(in_item_t w);
    out_item_t r;
    int slot;
    r = '0;
    r.event_ssrc = w.target_ssrc;
    slot = find_stream(w.target_ssrc);
    if (w.opcode >= OP_PAUSED && w.opcode <= OP_REQ_RESUME) begin
      if (slot < 0) begin
        // A new stream takes the lowest free slot.
        slot = 0;
        while (slot < TABLE_SIZE && trk_valid[slot]) slot++;
        if (slot == TABLE_SIZE) begin
          slot = -1;
        end else begin
          trk_valid[slot] = 1'b1;
          trk_ssrc[slot]  = w.target_ssrc;
          trk_state[slot] = ST_PLAYING;
          trk_pid[slot]   = '0;
        end
      end
      if (slot < 0) begin
        r.table_full = 1'b1;
      end else begin
        case (w.opcode)
          OP_PAUSED: begin
            trk_state[slot] = ST_PAUSED;
            trk_pid[slot]   = w.report_pause_id;
            r.ext_seq_out   = w.has_ext_seq ? w.ext_seq_in : '0;
            r.event_res     = EV_PAUSED;
          end
          OP_REFUSED: begin
            trk_state[slot] = ST_PLAYING;
            trk_pid[slot]   = w.report_pause_id;
            r.event_res     = EV_REFUSED;
          end
          OP_REQ_PAUSE: begin
            trk_state[slot] = ST_PAUSE_REQ;
            r.sender_ssrc   = own_ssrc;
            r.event_res     = EV_SEND_PAUSE;
          end
          default: begin
            trk_state[slot] = ST_RESUME_REQ;
            r.sender_ssrc   = own_ssrc;
            r.event_res     = EV_SEND_RESUME;
          end
        endcase
      end
    end else if (w.opcode == OP_RTP) begin
      if (slot >= 0 && (trk_state[slot] == ST_PAUSED || trk_state[slot] == ST_RESUME_REQ)) begin
        trk_state[slot] = ST_PLAYING;
        trk_pid[slot]   = trk_pid[slot] + 16'd1;
        r.event_res     = EV_RESUMED;
      end
    end else if (w.opcode == OP_QUERY) begin
      r.event_res = EV_QUERY;
    end
    if (slot >= 0) begin
      r.cur_pause_id = trk_pid[slot];
      r.cur_state    = trk_state[slot];
    end
    return r;
  endfunction

  // Mostly well-formed pause/resume traffic on the tracked streams, with some
  // arbitrary opcodes and a share of unknown streams that hit the full table.
  function automatic in_item_t random_word();
    in_item_t w;
    int slot;
    int pick;
    logic [1:0] st;
    w.report_pause_id = 16'($urandom);
    w.has_ext_seq     = 1'($urandom);
    w.ext_seq_in      = $urandom;
    if ($urandom_range(99) < 15) begin
      do w.target_ssrc = $urandom; while (find_stream(w.target_ssrc) >= 0);
      w.opcode = 3'($urandom);
      return w;
    end
    w.target_ssrc = stream_pool[$urandom_range(15)];
    slot = find_stream(w.target_ssrc);
    st = (slot >= 0) ? trk_state[slot] : ST_PLAYING;
    if (slot >= 0 && $urandom_range(3) < 2) w.report_pause_id = trk_pid[slot];
    else if ($urandom_range(1)) w.report_pause_id = 16'hFFFF;
    pick = $urandom_range(99);
    if (pick < 20) begin
      w.opcode = 3'($urandom);
    end else begin
      case (st)
        ST_PLAYING:   w.opcode = (pick < 70) ? OP_REQ_PAUSE : (pick < 90) ? OP_RTP : OP_QUERY;
        ST_PAUSE_REQ: w.opcode = (pick < 70) ? OP_PAUSED : (pick < 90) ? OP_REFUSED : OP_RTP;
        ST_PAUSED:    w.opcode = (pick < 65) ? OP_RTP : (pick < 90) ? OP_REQ_RESUME : OP_QUERY;
        default:      w.opcode = (pick < 70) ? OP_RTP : (pick < 85) ? OP_PAUSED : OP_REFUSED;
      endcase
    end
    return w;
  endfunction

  task automatic flag_mismatch(input string msg);
    // Output is capped so that a broken block cannot flood the log.
    if (error_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input logic [31:0] ssrc);
    if (got !== want)
      flag_mismatch($sformatf("stream %h %s got %h expected %h", ssrc, name, got, want));
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    check_field("event_res", 32'(got.event_res), 32'(want.event_res), want.event_ssrc);
    check_field("event_ssrc", got.event_ssrc, want.event_ssrc, want.event_ssrc);
    check_field("sender_ssrc", got.sender_ssrc, want.sender_ssrc, want.event_ssrc);
    check_field("cur_pause_id", 32'(got.cur_pause_id), 32'(want.cur_pause_id),
                want.event_ssrc);
    check_field("ext_seq_out", got.ext_seq_out, want.ext_seq_out, want.event_ssrc);
    check_field("cur_state", 32'(got.cur_state), 32'(want.cur_state), want.event_ssrc);
    check_field("table_full", 32'(got.table_full), 32'(want.table_full), want.event_ssrc);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_word(input in_item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_s.valid <= 1'b0;
      @(negedge clk);
    end
    in_s.valid           <= 1'b1;
    in_s.opcode          <= w.opcode;
    in_s.target_ssrc     <= w.target_ssrc;
    in_s.report_pause_id <= w.report_pause_id;
    in_s.has_ext_seq     <= w.has_ext_seq;
    in_s.ext_seq_in      <= w.ext_seq_in;
    do @(posedge clk); while (in_s.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_own_ssrc(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    own_ssrc = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain_results();
    in_s.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_s.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_s.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    in_item_t  seen;
    out_item_t got;
    out_item_t predicted;
    if (!rst) begin
      if (in_s.valid === 1'b1 && in_s.ready === 1'b1) begin
        seen = '{in_s.opcode, in_s.target_ssrc, in_s.report_pause_id, in_s.has_ext_seq,
                 in_s.ext_seq_in};
        predicted = step_tracker(seen);
        pending_results.push_back(row_typed ? row_want : predicted);
      end
      if (out_s.valid === 1'b1 && out_s.ready === 1'b1) begin
        got = '{out_s.event_res, out_s.event_ssrc, out_s.sender_ssrc, out_s.cur_pause_id,
                out_s.ext_seq_out, out_s.cur_state, out_s.table_full};
        if (pending_results.size() == 0)
          flag_mismatch($sformatf("result word for stream %h with nothing expected",
                                  got.event_ssrc));
        else
          check_result(got, pending_results.pop_front());
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stream_pause_resume_tracker_test failed");
    $finish;
  end

  initial begin
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    in_s.valid           = 1'b0;
    in_s.opcode          = OP_RTP;
    in_s.target_ssrc     = '0;
    in_s.report_pause_id = '0;
    in_s.has_ext_seq     = 1'b0;
    in_s.ext_seq_in      = '0;
    out_s.ready          = 1'b0;
    row_typed            = 1'b0;
    row_want             = '0;
    error_count          = 0;
    tx_idle_pct          = 0;
    rx_stall_pct         = 0;
    hold_left            = 0;
    own_ssrc             = '0;
    foreach (trk_valid[i]) trk_valid[i] = 1'b0;

    stream_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8765_4321,
                    32'h0000_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                    32'h00C0_FFEE, 32'h0F0F_0F0F, 32'h1357_9BDF, 32'h2468_ACE0};
    phase_ssrc = '{32'h0000_0000, $urandom, 32'h8000_0001, $urandom};

    // Directed words on an empty table, then each opcode on its own stream
    // until the table is full, then untracked streams against the full table.
    dir_rows.push_back('{'{OP_QUERY, 32'h0, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_QUERY, 32'h0, 32'h0, 16'h0, 32'h0, ST_PLAYING, 1'b0}});
    dir_rows.push_back('{'{OP_RTP, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF}, 1'b1,
                         '{EV_NONE, 32'hFFFF_FFFF, 32'h0, 16'h0, 32'h0, ST_PLAYING, 1'b0}});
    dir_rows.push_back('{'{OP_SPARE_6, 32'h0, 16'h1, 1'b1, 32'h1}, 1'b1,
                         '{EV_NONE, 32'h0, 32'h0, 16'h0, 32'h0, ST_PLAYING, 1'b0}});
    dir_rows.push_back('{'{OP_SPARE_7, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_NONE, 32'hFFFF_FFFF, 32'h0, 16'h0, 32'h0, ST_PLAYING, 1'b0}});
    dir_rows.push_back('{'{OP_REQ_PAUSE, 32'h0, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_SEND_PAUSE, 32'h0, 32'hFFFF_FFFF, 16'h0, 32'h0, ST_PAUSE_REQ,
                           1'b0}});
    dir_rows.push_back('{'{OP_RTP, 32'h0, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_NONE, 32'h0, 32'h0, 16'h0, 32'h0, ST_PAUSE_REQ, 1'b0}});
    dir_rows.push_back('{'{OP_PAUSED, 32'h0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF}, 1'b1,
                         '{EV_PAUSED, 32'h0, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, ST_PAUSED,
                           1'b0}});
    // The pause id wraps from all ones to zero on the resuming RTP word.
    dir_rows.push_back('{'{OP_RTP, 32'h0, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_RESUMED, 32'h0, 32'h0, 16'h0, 32'h0, ST_PLAYING, 1'b0}});
    dir_rows.push_back('{'{OP_PAUSED, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'hFFFF_FFFF}, 1'b1,
                         '{EV_PAUSED, 32'hFFFF_FFFF, 32'h0, 16'h0, 32'h0, ST_PAUSED, 1'b0}});
    dir_rows.push_back('{'{OP_REQ_RESUME, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_SEND_RESUME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 32'h0,
                           ST_RESUME_REQ, 1'b0}});
    dir_rows.push_back('{'{OP_RTP, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_RESUMED, 32'hFFFF_FFFF, 32'h0, 16'h1, 32'h0, ST_PLAYING,
                           1'b0}});
    dir_rows.push_back('{'{OP_REFUSED, 32'h0, 16'h7FFF, 1'b1, 32'h1234_5678}, 1'b1,
                         '{EV_REFUSED, 32'h0, 32'h0, 16'h7FFF, 32'h0, ST_PLAYING, 1'b0}});
    dir_rows.push_back('{'{OP_SPARE_6, 32'hFFFF_FFFF, 16'h0, 1'b1, 32'h5}, 1'b0, '0});
    for (int k = 2; k < 16; k++)
      dir_rows.push_back('{'{3'(OP_PAUSED + k % 4), stream_pool[k], 16'(k * 4099),
                             1'(k), 32'(k) * 32'h1111_1111}, 1'b0, '0});
    dir_rows.push_back('{'{OP_PAUSED, 32'h3C3C_3C3C, 16'hFFFF, 1'b1, 32'hFFFF_FFFF}, 1'b1,
                         '{EV_NONE, 32'h3C3C_3C3C, 32'h0, 16'h0, 32'h0, ST_PLAYING, 1'b1}});
    dir_rows.push_back('{'{OP_REQ_PAUSE, 32'hC3C3_C3C3, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_NONE, 32'hC3C3_C3C3, 32'h0, 16'h0, 32'h0, ST_PLAYING, 1'b1}});
    dir_rows.push_back('{'{OP_QUERY, 32'hC3C3_C3C3, 16'h0, 1'b0, 32'h0}, 1'b1,
                         '{EV_QUERY, 32'hC3C3_C3C3, 32'h0, 16'h0, 32'h0, ST_PLAYING, 1'b0}});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_own_ssrc(32'hFFFF_FFFF);

    foreach (dir_rows[i]) begin
      row_typed = dir_rows[i].typed;
      row_want  = dir_rows[i].want;
      offer_word(dir_rows[i].word);
    end
    row_typed = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_own_ssrc(phase_ssrc[ph]);
      tx_idle_pct  = phase_tx[ph];
      rx_stall_pct = phase_rx[ph];
      if (ph == 0) begin
        // Long receiver hold-off while words keep coming, so the block backs up.
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) offer_word(random_word());
    end

    drain_results();
    repeat (2 * (TABLE_SIZE + 3)) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("stream_pause_resume_tracker_test passed");
    end else begin
      $display("stream_pause_resume_tracker_test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/spr_pkg.sv
rtl/spr_if.sv
rtl/spr_ctrl.sv
rtl/spr_datapath.sv
rtl/stream_pause_resume_tracker.sv
rtl/spr_checker.sv
tb/stream_pause_resume_tracker_test.sv
